### design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### design/cafilt_pkg.sv
`timescale 1ns / 1ps

package cafilt_pkg;

    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;
    localparam int GAIN_W    = 16;
    localparam int DELAY_W   = 12;
    localparam int MODE_W    = 2;
    localparam int FRAC_BITS = 15;
    localparam int HALF_LSB  = 16384;
    localparam int QDEPTH    = 4;
    localparam int QAW       = 2;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_GAIN  = 2'd1;
    localparam logic [1:0] REG_DELAY = 2'd2;

    localparam logic [MODE_W-1:0] MODE_FEEDBACK    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FEEDFWD     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ALLPASS     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ALLPASS_ALT = 2'd3;

    typedef enum logic [1:0] {
        KIND_FB,
        KIND_FF,
        KIND_AP
    } t_kind;

    typedef struct packed {
        logic [MODE_W-1:0]         filter_mode;
        logic signed [GAIN_W-1:0]  gain;
        logic [DELAY_W-1:0]        delay_samples;
    } t_cfg;

    typedef struct packed {
        t_kind kind;
        logic  hist_ok;
    } t_req_ctl;

endpackage

### design/cafilt_regs.sv
`timescale 1ns / 1ps

module cafilt_regs
    import cafilt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;

    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[3:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.filter_mode   <= MODE_FEEDBACK;
            r_cfg.gain          <= 16'sh7FFF;
            r_cfg.delay_samples <= DELAY_W'(1);
        end else if (w_wr) begin
            unique case (w_idx)
                REG_MODE:  r_cfg.filter_mode   <= pwdata[MODE_W-1:0];
                REG_GAIN:  r_cfg.gain          <= pwdata[GAIN_W-1:0];
                REG_DELAY: r_cfg.delay_samples <= pwdata[DELAY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_MODE:  prdata = APB_DW'(r_cfg.filter_mode);
            REG_GAIN:  prdata = APB_DW'(unsigned'(r_cfg.gain));
            REG_DELAY: prdata = APB_DW'(r_cfg.delay_samples);
            default:   prdata = '0;
        endcase
    end

endmodule

### design/cafilt_front.sv
`timescale 1ns / 1ps

module cafilt_front
    import cafilt_pkg::*;
#(
    parameter int MAX_DELAY    = 4096,
    parameter int SAMPLE_WIDTH = 16,
    parameter int AW           = $clog2(MAX_DELAY)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_cfg                           i_cfg,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    output logic                           o_q_valid,
    output logic signed [SAMPLE_WIDTH-1:0] o_q_sample,
    output logic [AW-1:0]                  o_q_wp,
    output logic [AW-1:0]                  o_q_rd,
    output t_req_ctl                       o_q_ctl,
    input  logic                           i_q_pop
);

    localparam logic [31:0] DMAX  = 32'(MAX_DELAY - 1);
    localparam logic [AW:0] DEPTH = (AW + 1)'(MAX_DELAY);

    logic [AW-1:0] r_wp, n_wp;
    logic [AW:0]   r_fill, n_fill;
    logic [QAW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QAW:0]   r_count;

    logic signed [SAMPLE_WIDTH-1:0] r_q_sample [QDEPTH];
    logic [AW-1:0]                  r_q_wp     [QDEPTH];
    logic [AW-1:0]                  r_q_rd     [QDEPTH];
    t_req_ctl                       r_q_ctl    [QDEPTH];

    logic          w_push;
    logic [31:0]   w_d32, w_dclamp;
    logic [AW-1:0] w_d, w_rd;
    logic [AW:0]   w_rd_sum;
    t_req_ctl      w_ctl;

    assign o_in_stall = (r_count == (QAW + 1)'(QDEPTH));
    assign w_push     = i_in_valid && !o_in_stall;

    // Effective delay: zero acts as one, values past the store are clamped.
    assign w_d32    = 32'(i_cfg.delay_samples);
    assign w_dclamp = (w_d32 == 32'd0) ? 32'd1 : ((w_d32 > DMAX) ? DMAX : w_d32);
    assign w_d      = w_dclamp[AW-1:0];

    assign w_rd_sum = {1'b0, r_wp} + DEPTH - {1'b0, w_d};
    assign w_rd     = (w_rd_sum >= DEPTH) ? AW'(w_rd_sum - DEPTH) : w_rd_sum[AW-1:0];

    // History slots are written in order, so a slot holds data once enough
    // samples have gone by; otherwise its read is masked to zero in the back end.
    always_comb begin
        unique case (i_cfg.filter_mode)
            MODE_FEEDBACK: w_ctl.kind = KIND_FB;
            MODE_FEEDFWD:  w_ctl.kind = KIND_FF;
            default:       w_ctl.kind = KIND_AP;
        endcase
        w_ctl.hist_ok = (r_fill >= {1'b0, w_d});
    end

    assign n_wp   = (r_wp == AW'(MAX_DELAY - 1)) ? '0 : r_wp + AW'(1);
    assign n_fill = (r_fill == DEPTH) ? r_fill : r_fill + (AW + 1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_fill   <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wp     <= n_wp;
                r_fill   <= n_fill;
                r_wr_ptr <= r_wr_ptr + QAW'(1);
            end
            if (i_q_pop) begin
                r_rd_ptr <= r_rd_ptr + QAW'(1);
            end
            if (w_push && !i_q_pop) begin
                r_count <= r_count + (QAW + 1)'(1);
            end else if (!w_push && i_q_pop) begin
                r_count <= r_count - (QAW + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_sample[r_wr_ptr] <= i_sample_in;
            r_q_wp[r_wr_ptr]     <= r_wp;
            r_q_rd[r_wr_ptr]     <= w_rd;
            r_q_ctl[r_wr_ptr]    <= w_ctl;
        end
    end

    assign o_q_valid  = (r_count != '0);
    assign o_q_sample = r_q_sample[r_rd_ptr];
    assign o_q_wp     = r_q_wp[r_rd_ptr];
    assign o_q_rd     = r_q_rd[r_rd_ptr];
    assign o_q_ctl    = r_q_ctl[r_rd_ptr];

endmodule

### design/cafilt_back.sv
`timescale 1ns / 1ps

module cafilt_back
    import cafilt_pkg::*;
#(
    parameter int MAX_DELAY    = 4096,
    parameter int SAMPLE_WIDTH = 16,
    parameter int AW           = $clog2(MAX_DELAY)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic signed [GAIN_W-1:0]       i_gain,
    input  logic                           i_q_valid,
    input  logic signed [SAMPLE_WIDTH-1:0] i_q_sample,
    input  logic [AW-1:0]                  i_q_wp,
    input  logic [AW-1:0]                  i_q_rd,
    input  t_req_ctl                       i_q_ctl,
    output logic                           o_q_pop,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample_out
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int PW    = SW + GAIN_W;
    localparam int ACC_W = SW + GAIN_W + 1;
    localparam int EXT   = ACC_W - SW - FRAC_BITS;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(HALF_LSB);
    localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W - SW + 1){1'b1}}, {(SW - 1){1'b0}}};

    logic signed [SW-1:0] r_hist_x [MAX_DELAY];
    logic signed [SW-1:0] r_hist_y [MAX_DELAY];

    logic                 r_s1_valid;
    logic signed [SW-1:0] r_s1_sample;
    logic [AW-1:0]        r_s1_wp;
    t_req_ctl             r_s1_ctl;
    logic signed [SW-1:0] r_s1_xd, r_s1_yd;

    logic                    r_s2_valid;
    logic signed [SW-1:0]    r_s2_sample;
    logic [AW-1:0]           r_s2_wp;
    logic signed [ACC_W-1:0] r_t0, r_t1, r_t2;
    logic signed [ACC_W-1:0] n_t0, n_t1, n_t2;

    logic                 r_out_valid;
    logic signed [SW-1:0] r_out_y;

    logic                    w_adv, w_hazard, w_issue;
    logic signed [SW-1:0]    w_xd, w_yd, w_mb_src;
    logic signed [PW-1:0]    w_ma, w_mb;
    logic signed [ACC_W-1:0] w_ma_ext, w_mb_ext, w_x_sh, w_xd_sh;
    logic signed [ACC_W-1:0] w_acc, w_rnd;
    logic signed [SW-1:0]    w_y;

    // A slot still being computed in flight cannot be read yet.
    assign w_adv    = !r_out_valid || !i_out_stall;
    assign w_hazard = i_q_ctl.hist_ok &&
                      ((r_s1_valid && (r_s1_wp == i_q_rd)) ||
                       (r_s2_valid && (r_s2_wp == i_q_rd)));
    assign w_issue  = w_adv && i_q_valid && !w_hazard;
    assign o_q_pop  = w_issue;

    assign w_xd     = r_s1_ctl.hist_ok ? r_s1_xd : '0;
    assign w_yd     = r_s1_ctl.hist_ok ? r_s1_yd : '0;
    assign w_mb_src = (r_s1_ctl.kind == KIND_FF) ? w_xd : w_yd;
    assign w_ma     = i_gain * r_s1_sample;
    assign w_mb     = i_gain * w_mb_src;
    assign w_ma_ext = {{(ACC_W - PW){w_ma[PW-1]}}, w_ma};
    assign w_mb_ext = {{(ACC_W - PW){w_mb[PW-1]}}, w_mb};
    assign w_x_sh   = {{EXT{r_s1_sample[SW-1]}}, r_s1_sample, {FRAC_BITS{1'b0}}};
    assign w_xd_sh  = {{EXT{w_xd[SW-1]}}, w_xd, {FRAC_BITS{1'b0}}};

    always_comb begin
        case (r_s1_ctl.kind)
            KIND_AP: begin
                n_t0 = w_ma_ext;
                n_t1 = w_xd_sh;
                n_t2 = -w_mb_ext;
            end
            default: begin
                n_t0 = w_x_sh;
                n_t1 = w_mb_ext;
                n_t2 = '0;
            end
        endcase
    end

    assign w_acc = r_t0 + r_t1 + r_t2;
    assign w_rnd = (w_acc + ROUND_HALF) >>> FRAC_BITS;
    assign w_y   = (w_rnd > SAT_HI) ? SAT_HI[SW-1:0] :
                   ((w_rnd < SAT_LO) ? SAT_LO[SW-1:0] : w_rnd[SW-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid  <= w_issue;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_s1_sample <= i_q_sample;
            r_s1_wp     <= i_q_wp;
            r_s1_ctl    <= i_q_ctl;
        end
        if (w_adv && r_s1_valid) begin
            r_s2_sample <= r_s1_sample;
            r_s2_wp     <= r_s1_wp;
            r_t0        <= n_t0;
            r_t1        <= n_t1;
            r_t2        <= n_t2;
        end
        if (w_adv && r_s2_valid) begin
            r_out_y <= w_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s2_valid) begin
            r_hist_x[r_s2_wp] <= r_s2_sample;
        end
        if (w_issue) begin
            r_s1_xd <= r_hist_x[i_q_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s2_valid) begin
            r_hist_y[r_s2_wp] <= w_y;
        end
        if (w_issue) begin
            r_s1_yd <= r_hist_y[i_q_rd];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_y;

endmodule

### design/comb_allpass_audio_filter.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    i_sample_in
// output    out        o_out_valid / i_out_stall  o_sample_out
// config    in         APB psel/penable/pwrite    paddr, pwdata, prdata
// One request per cycle while the delay is three samples or more and the output does not stall.
// A delay of one or two waits on the write-back of the history memories,
// which happens as a request leaves stage s2; at a delay of one, each request
// waits on the one before it. A sample passes the front queue, s1, s2 and the output register.
// Reset needs no clearing pass; a fill count masks unwritten history.
// An output stall freezes the back pipeline while the front queue fills.

module comb_allpass_audio_filter
    import cafilt_pkg::*;
#(
    parameter int MAX_DELAY    = 4096,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [APB_AW-1:0]              paddr,
    input  logic [APB_DW-1:0]              pwdata,
    output logic [APB_DW-1:0]              prdata,
    output logic                           pready
);

`include "assert_macros.svh"

    localparam int AW = $clog2(MAX_DELAY);

    t_cfg                           w_cfg;
    logic                           w_q_valid, w_q_pop;
    logic signed [SAMPLE_WIDTH-1:0] w_q_sample;
    logic [AW-1:0]                  w_q_wp, w_q_rd;
    t_req_ctl                       w_q_ctl;
    logic                           w_mode_wr;
    logic [MODE_W-1:0]              w_mode_wdata;

    cafilt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    cafilt_front #(
        .MAX_DELAY    (MAX_DELAY),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .AW           (AW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sample_in (i_sample_in),
        .o_q_valid   (w_q_valid),
        .o_q_sample  (w_q_sample),
        .o_q_wp      (w_q_wp),
        .o_q_rd      (w_q_rd),
        .o_q_ctl     (w_q_ctl),
        .i_q_pop     (w_q_pop)
    );

    cafilt_back #(
        .MAX_DELAY    (MAX_DELAY),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .AW           (AW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_gain       (w_cfg.gain),
        .i_q_valid    (w_q_valid),
        .i_q_sample   (w_q_sample),
        .i_q_wp       (w_q_wp),
        .i_q_rd       (w_q_rd),
        .i_q_ctl      (w_q_ctl),
        .o_q_pop      (w_q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample_out (o_sample_out)
    );

    assign w_mode_wr    = psel && penable && pwrite && (paddr[3:2] == REG_MODE);
    assign w_mode_wdata = pwdata[MODE_W-1:0];

    `ASSERT_IMPL(a_pop_nonempty, i_clk, i_rst_n, w_q_pop, w_q_valid)
    `ASSERT_IMPL(a_stall_no_issue, i_clk, i_rst_n, o_out_valid && i_out_stall, !w_q_pop)
    `ASSERT_NEXT(a_mode_write, i_clk, i_rst_n, w_mode_wr, w_cfg.filter_mode == $past(w_mode_wdata))

endmodule
